// ===== rtl/tmf_pkg.sv =====
package tmf_pkg;

  // field and register widths
  localparam int PT_W          = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;

  // register indexes (byte address 4*i)
  localparam logic [1:0] REG_POINT_ONE   = 2'd0;
  localparam logic [1:0] REG_POINT_TWO   = 2'd1;
  localparam logic [1:0] REG_POINT_THREE = 2'd2;
  localparam logic [1:0] REG_POINT_FOUR  = 2'd3;

  // what the pipeline will produce for an item
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_DIV
  } kind_t;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

endpackage

// ===== rtl/tmf_div_stage.sv =====
module tmf_div_stage
  import tmf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 in_ctl,
  input  logic [PT_W-1:0]      in_rem,
  input  logic [PT_W-1:0]      in_den,
  input  logic [FRAC_BITS-1:0] in_q,
  output ctl_t                 out_ctl,
  output logic [PT_W-1:0]      out_rem,
  output logic [PT_W-1:0]      out_den,
  output logic [FRAC_BITS-1:0] out_q
);

  logic [PT_W:0]   shifted;
  logic [PT_W+1:0] diff;
  logic            take;

  // one restoring step: shift remainder, subtract divisor if it fits
  always_comb begin
    shifted = {in_rem, 1'b0};
    diff    = {1'b0, shifted} - {2'b00, in_den};
    take    = !diff[PT_W+1];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '{valid: 1'b0, kind: KIND_ZERO};
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= take ? diff[PT_W-1:0] : shifted[PT_W-1:0];
      out_den <= in_den;
      out_q   <= {in_q[FRAC_BITS-2:0], take};
    end
  end

endmodule

// ===== rtl/trapezoid_membership_core.sv =====
// channel  | dir | handshake        | payload
// s_*      | in  | s_tvalid/tready  | s_tdata[31:0] sample, signed Q16.16
// m_*      | out | m_tvalid/tready  | m_tdata[FRAC_BITS:0] membership, unsigned
// apb      | in  | psel/penable     | paddr 4*i, pwdata point_one..point_four
//
// the pipe is one classify stage, one restoring divide stage per quotient bit
// and one output register; one item enters every cycle while m_tready does not stall the pipe.
// reset (rst, synchronous) clears all valid bits and the four points to 0.
// a stall on m_tready freezes the whole pipe; s_tready drops only while the
// output register holds an item that is not being taken.
module trapezoid_membership_core
  import tmf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PT_W-1:0]       s_tdata,   // [31:0] sample
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [((FRAC_BITS+8)/8)*8-1:0] m_tdata, // [FRAC_BITS:0] membership, zero fill
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int MEMB_W = FRAC_BITS + 1;
  localparam int TD_W   = ((FRAC_BITS + 8) / 8) * 8;
  localparam logic [MEMB_W-1:0] MEMB_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic signed [PT_W-1:0] point_one;
  logic signed [PT_W-1:0] point_two;
  logic signed [PT_W-1:0] point_three;
  logic signed [PT_W-1:0] point_four;

  logic [1:0] reg_idx;
  logic       cfg_wr;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_one   <= '0;
      point_two   <= '0;
      point_three <= '0;
      point_four  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_POINT_ONE:   point_one   <= pwdata;
        REG_POINT_TWO:   point_two   <= pwdata;
        REG_POINT_THREE: point_three <= pwdata;
        REG_POINT_FOUR:  point_four  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POINT_ONE:   prdata = point_one;
      REG_POINT_TWO:   prdata = point_two;
      REG_POINT_THREE: prdata = point_three;
      REG_POINT_FOUR:  prdata = point_four;
      default:         prdata = '0;
    endcase
  end

  // pipe advances whenever the output register can move
  logic en;
  logic out_valid;
  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  // classify the sample against the trapezoid
  logic signed [PT_W-1:0] smp;
  logic                   order_ok;
  logic                   plateau;
  logic                   outside;
  logic                   rising;
  logic signed [PT_W:0]   num_rise;
  logic signed [PT_W:0]   num_fall;
  logic signed [PT_W:0]   den_rise;
  logic signed [PT_W:0]   den_fall;
  kind_t                  kind_in;
  logic [PT_W-1:0]        num_in;
  logic [PT_W-1:0]        den_in;

  always_comb begin
    smp      = s_tdata;
    order_ok = (point_one <= point_two) && (point_two <= point_three)
               && (point_three <= point_four);
    plateau  = (smp >= point_two) && (smp <= point_three);
    outside  = (smp <= point_one) || (smp >= point_four);
    rising   = smp < point_two;
    num_rise = {smp[PT_W-1], smp} - {point_one[PT_W-1], point_one};
    num_fall = {point_four[PT_W-1], point_four} - {smp[PT_W-1], smp};
    den_rise = {point_two[PT_W-1], point_two} - {point_one[PT_W-1], point_one};
    den_fall = {point_four[PT_W-1], point_four} - {point_three[PT_W-1], point_three};
    if (!order_ok) begin
      kind_in = KIND_ZERO;
    end else if (plateau) begin
      kind_in = KIND_ONE;
    end else if (outside) begin
      kind_in = KIND_ZERO;
    end else begin
      kind_in = KIND_DIV;
    end
    num_in = rising ? num_rise[PT_W-1:0] : num_fall[PT_W-1:0];
    den_in = rising ? den_rise[PT_W-1:0] : den_fall[PT_W-1:0];
  end

  // pipe registers, index 0 is the classify stage
  ctl_t                 ctl [FRAC_BITS+1];
  logic [PT_W-1:0]      rem [FRAC_BITS+1];
  logic [PT_W-1:0]      den [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '{valid: 1'b0, kind: KIND_ZERO};
    end else if (en) begin
      ctl[0] <= '{valid: s_tvalid, kind: kind_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_in;
      den[0] <= den_in;
      quo[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    tmf_div_stage #(
      .FRAC_BITS(FRAC_BITS)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .in_ctl (ctl[k]),
      .in_rem (rem[k]),
      .in_den (den[k]),
      .in_q   (quo[k]),
      .out_ctl(ctl[k+1]),
      .out_rem(rem[k+1]),
      .out_den(den[k+1]),
      .out_q  (quo[k+1])
    );
  end

  // output register
  logic [MEMB_W-1:0] memb_sel;
  logic [MEMB_W-1:0] membership;

  always_comb begin
    case (ctl[FRAC_BITS].kind)
      KIND_ONE: memb_sel = MEMB_ONE;
      KIND_DIV: memb_sel = {1'b0, quo[FRAC_BITS]};
      default:  memb_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      membership <= memb_sel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TD_W-MEMB_W){1'b0}}, membership};

  // a divide item always has 0 < numerator < divisor
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    ctl[0].valid && ctl[0].kind == KIND_DIV |-> rem[0] != '0 && rem[0] < den[0])
    else $error("divide operands out of range");

  // membership never exceeds one
  a_memb_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> membership <= MEMB_ONE)
    else $error("membership above one");

  // a stall freezes the classify stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en && ctl[0].valid |=> ctl[0].valid && $stable(rem[0]) && $stable(den[0]))
    else $error("classify stage moved during stall");

  // a divide result has the top bit clear
  a_div_top: assert property (@(posedge clk) disable iff (rst)
    ctl[FRAC_BITS].valid && ctl[FRAC_BITS].kind == KIND_DIV |-> memb_sel[FRAC_BITS] == 1'b0)
    else $error("divide quotient overflow");

endmodule

// ===== verif/membership_checker.sv =====
`timescale 1ns / 100ps

module membership_checker
  import tmf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  input  logic                                   s_tready,
  input  logic [PT_W-1:0]                        s_tdata,   // [31:0] sample
  input  logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic [((FRAC_BITS+8)/8)*8-1:0]         m_tdata,   // [FRAC_BITS:0] membership, zero fill
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic                                   pready,
  input  logic [CFG_ADDR_W-1:0]                  paddr,
  input  logic [CFG_DATA_W-1:0]                  pwdata,
  output int                                     grade_errors,
  output int                                     grades_pending
);

  localparam int OUT_W = ((FRAC_BITS + 8) / 8) * 8;

  // local copy of the four corners
  logic signed [PT_W-1:0] foot_lo;
  logic signed [PT_W-1:0] shoulder_lo;
  logic signed [PT_W-1:0] shoulder_hi;
  logic signed [PT_W-1:0] foot_hi;

  // grades still owed by the block, oldest first
  logic [OUT_W-1:0] grades_due[$];

  // trapezoid grade of one sample under the current corners
  function automatic logic [FRAC_BITS:0] trapezoid_grade(input logic signed [PT_W-1:0] x);
    longint s;
    longint a;
    longint b;
    longint c;
    longint d;
    longint grade;
    s = x;
    a = foot_lo;
    b = shoulder_lo;
    c = shoulder_hi;
    d = foot_hi;
    if (a > b || b > c || c > d) grade = 0;
    else if (s >= b && s <= c) grade = longint'(1) <<< FRAC_BITS;
    else if (s <= a || s >= d) grade = 0;
    else if (s < b) grade = ((s - a) <<< FRAC_BITS) / (b - a);
    else grade = ((d - s) <<< FRAC_BITS) / (d - c);
    return grade[FRAC_BITS:0];
  endfunction

  initial begin
    grade_errors   = 0;
    grades_pending = 0;
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      foot_lo     <= '0;
      shoulder_lo <= '0;
      shoulder_hi <= '0;
      foot_hi     <= '0;
      grades_due.delete();
    end else begin
      // register writes seen on the config port
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[3:2])
          REG_POINT_ONE:   foot_lo     <= pwdata;
          REG_POINT_TWO:   shoulder_lo <= pwdata;
          REG_POINT_THREE: shoulder_hi <= pwdata;
          REG_POINT_FOUR:  foot_hi     <= pwdata;
          default: ;
        endcase
      end

      // accepted sample: one grade owed
      if (s_tvalid && s_tready)
        grades_due.push_back(OUT_W'(trapezoid_grade(s_tdata)));

      // accepted grade: compare with the oldest one owed
      if (m_tvalid && m_tready) begin
        if (grades_due.size() == 0) begin
          if (grade_errors < 10)
            $display("%0t: membership item with none pending, got %0d (tdata %h)",
                     $realtime, m_tdata[FRAC_BITS:0], m_tdata);
          grade_errors = grade_errors + 1;
        end else begin
          want = grades_due.pop_front();
          if (m_tdata !== want) begin
            if (grade_errors < 10)
              $display("%0t: membership expected %0d (tdata %h), got %0d (tdata %h)",
                       $realtime, want[FRAC_BITS:0], want, m_tdata[FRAC_BITS:0], m_tdata);
            grade_errors = grade_errors + 1;
          end
        end
      end
    end
    grades_pending <= grades_due.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tmf_pkg::*;

  localparam int OUT_W       = ((FRAC_BITS_DEF + 8) / 8) * 8;
  localparam int LATENCY     = FRAC_BITS_DEF + 2;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PT_W-1:0]       s_tdata = '0;   // [31:0] sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;        // [16:0] membership, zero fill
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int grade_errors;
  int grades_pending;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  logic signed [PT_W-1:0] corner [4];

  trapezoid_membership_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  membership_checker grade_check (.*);

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offer one sample, keeping valid high on return
  task automatic push_sample(input logic [PT_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every owed grade
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (grades_pending != 0);
  endtask

  // setup and access cycle, psel left high for a following write
  task automatic write_point(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_corners();
    wait_drained();
    write_point(REG_POINT_ONE,   corner[0]);
    write_point(REG_POINT_TWO,   corner[1]);
    write_point(REG_POINT_THREE, corner[2]);
    write_point(REG_POINT_FOUR,  corner[3]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_corners(input logic [PT_W-1:0] a, b, c, d);
    corner[0] = a;
    corner[1] = b;
    corner[2] = c;
    corner[3] = d;
    load_corners();
  endtask

  // random corners: wide, narrow or tight spread, sometimes degenerate
  task automatic draw_corners();
    int unsigned spread_kind;
    int unsigned k;
    logic signed [PT_W-1:0] base;
    logic signed [PT_W-1:0] tmp;
    spread_kind = $urandom_range(2);
    base = $urandom;
    for (int i = 0; i < 4; i++) begin
      case (spread_kind)
        0:       corner[i] = $urandom;
        1:       corner[i] = base + $urandom_range(1 << 20);
        default: corner[i] = base + $urandom_range(255);
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (corner[j] > corner[j+1]) begin
          tmp = corner[j];
          corner[j] = corner[j+1];
          corner[j+1] = tmp;
        end
      end
    end
    // zero-width edge or plateau
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(2);
      corner[k+1] = corner[k];
    end
    // corners out of order
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(2);
      tmp = corner[k];
      corner[k] = corner[k+1];
      corner[k+1] = tmp;
    end
  endtask

  // mostly samples inside the trapezoid span, some at corners, some anywhere
  function automatic logic [PT_W-1:0] draw_sample();
    int unsigned pick;
    longint span;
    pick = $urandom_range(9);
    span = longint'(corner[3]) - longint'(corner[0]);
    if (pick < 2) return $urandom;
    if (pick < 4) return corner[$urandom_range(3)] + $urandom_range(2) - 1;
    if (span > 0) return corner[0] + $urandom_range(span[31:0]);
    return $urandom;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset corners, all at zero
    push_sample(32'h0000_0000);
    push_sample(32'h0000_0001);

    // regular trapezoid: both edges, corners and plateau
    set_corners(32'hFFFE_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0003_0000);
    push_sample(32'hFFFE_0000);
    push_sample(32'hFFFE_0001);
    push_sample(32'hFFFE_8000);
    push_sample(32'hFFFE_FFFF);
    push_sample(32'hFFFF_0000);
    push_sample(32'h0000_0000);
    push_sample(32'h0001_0000);
    push_sample(32'h0001_0001);
    push_sample(32'h0002_0000);
    push_sample(32'h0002_FFFF);
    push_sample(32'h0003_0000);

    // widest edges
    set_corners(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h8000_0001);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h0000_0000);
    push_sample(32'h7FFF_FFFE);
    push_sample(32'h7FFF_FFFF);

    // corners out of order
    set_corners(32'd10, 32'd5, 32'd20, 32'd30);
    push_sample(32'd15);
    set_corners(32'd0, 32'd5, 32'd30, 32'd20);
    push_sample(32'd10);

    // shoulders on the feet: plateau wins
    set_corners(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
    push_sample(32'h0001_0000);
    push_sample(32'h0002_0000);
    push_sample(32'h0000_FFFF);

    // random phases with different idle patterns
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 57; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        draw_corners();
        load_corners();
        for (int n = 0; n < 50; n++) begin
          if (mode == 0 && sub == 0 && n == 20) hold_go = 1'b1;
          push_sample(draw_sample());
        end
      end
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (grade_errors == 0 && grades_pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== trapezoid_membership_core.f =====
rtl/tmf_pkg.sv
rtl/tmf_div_stage.sv
rtl/trapezoid_membership_core.sv
verif/membership_checker.sv
verif/testbench.sv
